// File: design/assert_macros.svh
// Assertion macros used by eit_section_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: design/eitp_pkg.sv
package eitp_pkg;
    localparam int unsigned MAX_EVENTS       = 64;
    localparam int unsigned MAX_DESCRIPTORS  = 16;
    localparam int unsigned MIN_SECTION_SIZE = 18;
    localparam int unsigned MAX_SECTION_SIZE = 4096;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_DESC   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [7:0] STATUS_OK   = 8'd0;
    localparam logic [7:0] STATUS_CRC  = 8'd1;
    localparam logic [7:0] STATUS_SIZE = 8'd2;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key_word;
        logic [15:0] aux_word;
        logic [23:0] aux_wide;
        logic [11:0] length_field;
        logic [39:0] wide_value;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [7:0]  byte_d;
        logic [7:0]  byte_e;
        logic [5:0]  byte_f;
    } record_t;

    // Up to three records from one byte.
    typedef struct packed {
        logic [1:0] count;
        record_t    rec0;
        record_t    rec1;
        record_t    rec2;
    } rec_group_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
        end
        return c;
    endfunction
endpackage

// File: design/eitp_stream_if.sv
interface eitp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/eitp_front.sv
module eitp_front
    import eitp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_item_t   in_item,
    output logic       in_ready,
    output logic       grp_valid,
    output rec_group_t grp,
    input  logic       grp_ready
);
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_EVHDR  = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]   phase_reg, phase_next;
    logic [12:0]  pos_reg, pos_next;
    logic [111:0] acc_reg, acc_next;
    logic [12:0]  ev_left_reg, ev_left_next;
    logic [11:0]  d_left_reg, d_left_next;
    logic [7:0]   skip_reg, skip_next;
    logic [7:0]   tag_reg, tag_next;
    logic [8:0]   events_reg, events_next;
    logic [11:0]  descs_reg, descs_next;
    logic [31:0]  crc_reg, crc_next;
    logic [31:0]  tail_reg, tail_next;

    logic         take;
    logic [7:0]   b;
    logic [111:0] sh;
    rec_group_t   g;
    record_t      r;
    logic [11:0]  sl;
    logic         fin;
    logic [13:0]  size;

    assign in_ready  = grp_ready;
    assign take      = in_valid && in_ready;
    assign b         = in_item.data_byte;
    assign sh        = {acc_reg[103:0], b};
    assign grp_valid = take && (g.count != 2'd0);
    assign grp       = g;

    function automatic logic [7:0] ab(input logic [111:0] a, input int n, input int i);
        return a[(n - 1 - i) * 8 +: 8];
    endfunction

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        ev_left_next = ev_left_reg;
        d_left_next  = d_left_reg;
        skip_next    = skip_reg;
        tag_next     = tag_reg;
        events_next  = events_reg;
        descs_next   = descs_reg;
        crc_next     = (pos_reg >= 13'd4) ? crc_byte(crc_reg, tail_reg[31:24]) : crc_reg;
        tail_next    = {tail_reg[23:0], b};
        g            = '0;
        r            = '0;
        sl           = '0;
        fin          = 1'b0;
        size         = {1'b0, pos_reg} + 14'd1;

        if (phase_reg >= PH_EVHDR && phase_reg <= PH_SKIP && ev_left_reg != 13'd0)
        begin
            ev_left_next = ev_left_reg - 13'd1;
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                acc_next = sh;
                if (pos_reg == 13'd13)
                begin
                    sl = {4'(ab(sh, 14, 1)), ab(sh, 14, 2)};
                    r = '0;
                    r.kind = KIND_HEADER;
                    r.key_word = {ab(sh, 14, 3), ab(sh, 14, 4)};
                    r.aux_word = {ab(sh, 14, 8), ab(sh, 14, 9)};
                    r.aux_wide = {8'd0, ab(sh, 14, 10), ab(sh, 14, 11)};
                    r.length_field = sl;
                    r.byte_a = ab(sh, 14, 0);
                    r.byte_b = ab(sh, 14, 6);
                    r.byte_c = ab(sh, 14, 7);
                    r.byte_d = ab(sh, 14, 12);
                    r.byte_e = ab(sh, 14, 13);
                    r.byte_f = 6'(ab(sh, 14, 5));
                    g.rec0 = r;
                    g.count = 2'd1;
                    ev_left_next = (sl > 12'd15) ? {1'b0, sl - 12'd15} : 13'd0;
                    if (ev_left_next >= 13'd12 && events_reg < 9'(MAX_EVENTS))
                    begin
                        phase_next = PH_EVHDR;
                        skip_next  = '0;
                        descs_next = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_EVHDR:
            begin
                acc_next  = sh;
                skip_next = skip_reg + 8'd1;
                if (skip_next >= 8'd12)
                begin
                    d_left_next = {4'(ab(sh, 12, 10)), ab(sh, 12, 11)};
                    skip_next   = '0;
                    if (d_left_next == 12'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_TAG, PH_LEN, PH_BODY, PH_SKIP:
            begin
                if (phase_reg == PH_TAG)
                begin
                    if (d_left_reg >= 12'd2 && descs_reg < 12'(MAX_DESCRIPTORS))
                    begin
                        tag_next   = b;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else if (phase_reg == PH_LEN)
                begin
                    r = '0;
                    r.kind = KIND_DESC;
                    r.key_word = (pos_reg != 13'd0) ? 16'(pos_reg - 13'd1) : 16'd0;
                    r.byte_a = tag_reg;
                    r.byte_b = b;
                    r.byte_c = descs_reg[7:0];
                    g.rec0 = r;
                    g.count = 2'd1;
                    descs_next = descs_reg + 12'd1;
                    skip_next  = b;
                    phase_next = (b != 8'd0) ? PH_BODY : PH_TAG;
                end
                else if (phase_reg == PH_BODY)
                begin
                    if (skip_reg != 8'd0)
                    begin
                        skip_next = skip_reg - 8'd1;
                    end
                    if (skip_next == 8'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                if (d_left_reg != 12'd0)
                begin
                    d_left_next = d_left_reg - 12'd1;
                end
                if (d_left_next == 12'd0)
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            r = '0;
            r.kind = KIND_EVENT;
            r.key_word = {ab(acc_next, 12, 0), ab(acc_next, 12, 1)};
            r.aux_wide = {ab(acc_next, 12, 7), ab(acc_next, 12, 8), ab(acc_next, 12, 9)};
            r.length_field = {4'(ab(acc_next, 12, 10)), ab(acc_next, 12, 11)};
            r.wide_value = {ab(acc_next, 12, 2), ab(acc_next, 12, 3), ab(acc_next, 12, 4),
                            ab(acc_next, 12, 5), ab(acc_next, 12, 6)};
            r.byte_a = {5'd0, 3'(ab(acc_next, 12, 10) >> 5)};
            r.byte_b = {7'd0, 1'(ab(acc_next, 12, 10) >> 4)};
            r.byte_c = descs_next[7:0];
            if (g.count == 2'd0)
            begin
                g.rec0 = r;
            end
            else
            begin
                g.rec1 = r;
            end
            g.count = g.count + 2'd1;
            events_next = events_reg + 9'd1;
            if (ev_left_next >= 13'd12 && events_next < 9'(MAX_EVENTS))
            begin
                phase_next = PH_EVHDR;
                skip_next  = '0;
                descs_next = '0;
                acc_next   = '0;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (pos_reg != 13'h1FFF)
        begin
            pos_next = pos_reg + 13'd1;
        end

        if (in_item.last_byte)
        begin
            r = '0;
            r.kind = KIND_STATUS;
            r.wide_value = {8'd0, crc_next};
            if (size < 14'(MIN_SECTION_SIZE) || size > 14'(MAX_SECTION_SIZE))
            begin
                r.byte_a = STATUS_SIZE;
            end
            else if (crc_next != tail_next)
            begin
                r.byte_a = STATUS_CRC;
            end
            else
            begin
                r.byte_a = STATUS_OK;
            end
            r.byte_b = (events_next > 9'd255) ? 8'd255 : events_next[7:0];
            unique case (g.count)
                2'd0:    g.rec0 = r;
                2'd1:    g.rec1 = r;
                default: g.rec2 = r;
            endcase
            g.count = g.count + 2'd1;
            phase_next   = PH_HEADER;
            pos_next     = '0;
            acc_next     = '0;
            ev_left_next = '0;
            d_left_next  = '0;
            skip_next    = '0;
            tag_next     = '0;
            events_next  = '0;
            descs_next   = '0;
            crc_next     = '1;
            tail_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            acc_reg     <= '0;
            ev_left_reg <= '0;
            d_left_reg  <= '0;
            skip_reg    <= '0;
            tag_reg     <= '0;
            events_reg  <= '0;
            descs_reg   <= '0;
            crc_reg     <= '1;
            tail_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            ev_left_reg <= ev_left_next;
            d_left_reg  <= d_left_next;
            skip_reg    <= skip_next;
            tag_reg     <= tag_next;
            events_reg  <= events_next;
            descs_reg   <= descs_next;
            crc_reg     <= crc_next;
            tail_reg    <= tail_next;
        end
    end
endmodule

// File: design/eitp_queue.sv
module eitp_queue
    import eitp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  rec_group_t wr_data,
    output logic       wr_ready,
    output logic       rd_valid,
    output rec_group_t rd_data,
    input  logic       rd_ready
);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    rec_group_t      mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign wr_ready = cnt_reg != (AW + 1)'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end
endmodule

// File: design/eitp_back.sv
module eitp_back
    import eitp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    input  rec_group_t grp,
    output logic       grp_ready,
    output logic       out_valid,
    output record_t    out_rec,
    input  logic       out_ready
);
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    record_t    out_rec_reg;
    record_t    cur;
    logic       load;
    logic       last_of_grp;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur = grp.rec0;
            2'd1:    cur = grp.rec1;
            default: cur = grp.rec2;
        endcase
    end

    assign load        = grp_valid && (!out_valid_reg || out_ready);
    assign last_of_grp = (idx_reg + 2'd1) >= grp.count;
    assign grp_ready   = load && last_of_grp;
    assign out_valid   = out_valid_reg;
    assign out_rec     = out_rec_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rec_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_of_grp ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// File: design/eit_section_parser.sv
// Channel   Role   Payload
// in_ch     sink   in_item_t: data_byte, last_byte
// out_ch    source record_t: kind, key_word, aux_word, aux_wide, length_field,
//                  wide_value, byte_a .. byte_f
//
// One byte is taken per cycle; the byte parser and running CRC-32 update on
// each byte, so the rate is one byte per clock while the result queue has room.
// A byte gives zero to three records; the back end emits one record per cycle
// while the output is ready; a group holds its queue slot until all are loaded.
// Reset clears parse state, CRC (to all ones), the queue and output valid flag.
// A stall on the output fills the four-entry queue, then input ready drops.
`include "assert_macros.svh"
module eit_section_parser
    import eitp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    eitp_stream_if.sink   in_ch,
    eitp_stream_if.source out_ch
);
    logic       f_valid, f_ready, q_valid, q_ready;
    rec_group_t f_grp, q_grp;

    // Front: consumes bytes, runs the CRC and field parser.
    eitp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_item   (in_ch.payload),
        .in_ready  (in_ch.ready),
        .grp_valid (f_valid),
        .grp       (f_grp),
        .grp_ready (f_ready)
    );

    // Short queue that decouples the parser from the output side.
    eitp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_data  (f_grp),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_data  (q_grp),
        .rd_ready (q_ready)
    );

    // Back: serializes each group of records onto the output channel.
    eitp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (q_valid),
        .grp       (q_grp),
        .grp_ready (q_ready),
        .out_valid (out_ch.valid),
        .out_rec   (out_ch.payload),
        .out_ready (out_ch.ready)
    );

    // A stored group always holds at least one record.
    `ASSERT_IMPLIES(a_grp_nonempty, clk, rst_n, q_valid, q_grp.count != 2'd0)
    // A transaction is only taken when the queue can absorb its records.
    `ASSERT_IMPLIES(a_in_room, clk, rst_n, in_ch.valid && in_ch.ready, f_ready)
    // An output transaction with no new load leaves the output empty.
    `ASSERT_NEXT(a_out_drain, clk, rst_n, out_ch.valid && out_ch.ready && !q_valid, !out_ch.valid)
endmodule

// File: tb/sv/eit_section_parser_test.sv
module eit_section_parser_test;
    import eitp_pkg::*;

    // The parser takes one section byte per transaction and answers with
    // header, event, descriptor and status records. This bench builds
    // sections with valid structure and CRC, plus corrupted, short and
    // truncated ones. It predicts every record in order and compares the
    // records that come out against them.

    logic clk;
    logic rst_n;

    eitp_stream_if #(.payload_t(in_item_t)) in_ch ();
    eitp_stream_if #(.payload_t(record_t))  out_ch ();

    eit_section_parser uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    localparam int IDLE_LIMIT = 20000;

    // Bytes waiting to be sent, and the records the parser should produce.
    in_item_t byte_queue[$];
    record_t  record_queue[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int idle_cycles;
    bit failed;

    // Set at the rising edge when the offered transaction has been taken.
    bit in_accepted_q;

    // Predictor state. These variables track the parser's internal state.
    typedef enum logic [2:0]
    {
        PH_HEADER,
        PH_EVHDR,
        PH_TAG,
        PH_LEN,
        PH_BODY,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t      phase;
    logic [12:0] position;
    logic [7:0]  window[14];
    logic [12:0] loop_left;
    logic [11:0] desc_left;
    logic [7:0]  skip_count;
    logic [7:0]  held_tag;
    logic [8:0]  events_done;
    logic [11:0] desc_count;
    logic [31:0] running_crc;
    logic [31:0] tail_word;

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++)
        begin
            c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
        end
        return c;
    endfunction

    task automatic clear_predictor();
        phase = PH_HEADER;
        position = '0;
        for (int i = 0; i < 14; i++)
        begin
            window[i] = '0;
        end
        loop_left = '0;
        desc_left = '0;
        skip_count = '0;
        held_tag = '0;
        events_done = '0;
        desc_count = '0;
        running_crc = 32'hFFFFFFFF;
        tail_word = '0;
    endtask

    // window[13] is the newest byte; window[14 - n + i] is byte i of the last n.
    function automatic logic [7:0] recent(input int n, input int i);
        return window[14 - n + i];
    endfunction

    task automatic shift_in(input logic [7:0] b);
        for (int i = 0; i < 13; i++)
        begin
            window[i] = window[i + 1];
        end
        window[13] = b;
    endtask

    task automatic next_event();
        if (loop_left >= 12 && events_done < MAX_EVENTS)
        begin
            phase = PH_EVHDR;
            skip_count = '0;
            desc_count = '0;
            for (int i = 0; i < 14; i++)
            begin
                window[i] = '0;
            end
        end
        else
        begin
            phase = PH_DONE;
        end
    endtask

    task automatic close_event();
        record_t r;
        r = '0;
        r.kind = KIND_EVENT;
        r.key_word = {recent(12, 0), recent(12, 1)};
        r.wide_value = {recent(12, 2), recent(12, 3), recent(12, 4), recent(12, 5),
                        recent(12, 6)};
        r.aux_wide = {recent(12, 7), recent(12, 8), recent(12, 9)};
        r.length_field = {4'(recent(12, 10)), recent(12, 11)};
        r.byte_a = {5'd0, 3'(recent(12, 10) >> 5)};
        r.byte_b = {7'd0, 1'(recent(12, 10) >> 4)};
        r.byte_c = desc_count[7:0];
        record_queue.push_back(r);
        events_done++;
        next_event();
    endtask

    // Works out the records that one accepted byte causes.
    task automatic predict_byte(input in_item_t item);
        record_t     r;
        logic [12:0] p;
        logic [7:0]  b;
        logic [11:0] sl;
        int          size;
        p = position;
        b = item.data_byte;
        if (p >= 4)
        begin
            running_crc = crc_update(running_crc, tail_word[31:24]);
        end
        tail_word = {tail_word[23:0], b};
        if (phase >= PH_EVHDR && phase <= PH_SKIP && loop_left > 0)
        begin
            loop_left--;
        end
        case (phase)
            PH_HEADER:
            begin
                shift_in(b);
                if (p == 13)
                begin
                    sl = {4'(recent(14, 1)), recent(14, 2)};
                    r = '0;
                    r.kind = KIND_HEADER;
                    r.key_word = {recent(14, 3), recent(14, 4)};
                    r.aux_word = {recent(14, 8), recent(14, 9)};
                    r.aux_wide = {8'd0, recent(14, 10), recent(14, 11)};
                    r.length_field = sl;
                    r.byte_a = recent(14, 0);
                    r.byte_b = recent(14, 6);
                    r.byte_c = recent(14, 7);
                    r.byte_d = recent(14, 12);
                    r.byte_e = recent(14, 13);
                    r.byte_f = 6'(recent(14, 5));
                    record_queue.push_back(r);
                    loop_left = (sl > 15) ? 13'(sl - 15) : '0;
                    next_event();
                end
            end
            PH_EVHDR:
            begin
                shift_in(b);
                skip_count++;
                if (skip_count >= 12)
                begin
                    desc_left = {4'(recent(12, 10)), recent(12, 11)};
                    skip_count = '0;
                    if (desc_left == 0)
                    begin
                        close_event();
                    end
                    else
                    begin
                        phase = PH_TAG;
                    end
                end
            end
            PH_TAG, PH_LEN, PH_BODY, PH_SKIP:
            begin
                if (phase == PH_TAG)
                begin
                    if (desc_left >= 2 && desc_count < MAX_DESCRIPTORS)
                    begin
                        held_tag = b;
                        phase = PH_LEN;
                    end
                    else
                    begin
                        phase = PH_SKIP;
                    end
                end
                else if (phase == PH_LEN)
                begin
                    r = '0;
                    r.kind = KIND_DESC;
                    r.key_word = (p > 0) ? 16'(p - 1) : '0;
                    r.byte_a = held_tag;
                    r.byte_b = b;
                    r.byte_c = desc_count[7:0];
                    record_queue.push_back(r);
                    desc_count++;
                    skip_count = b;
                    phase = (b != 0) ? PH_BODY : PH_TAG;
                end
                else if (phase == PH_BODY)
                begin
                    if (skip_count > 0)
                    begin
                        skip_count--;
                    end
                    if (skip_count == 0)
                    begin
                        phase = PH_TAG;
                    end
                end
                if (desc_left > 0)
                begin
                    desc_left--;
                end
                if (desc_left == 0)
                begin
                    close_event();
                end
            end
            default:
            begin
            end
        endcase
        if (position < 13'd8191)
        begin
            position++;
        end
        if (item.last_byte)
        begin
            size = int'(p) + 1;
            r = '0;
            r.kind = KIND_STATUS;
            r.wide_value = {8'd0, running_crc};
            if (size < MIN_SECTION_SIZE || size > MAX_SECTION_SIZE)
            begin
                r.byte_a = STATUS_SIZE;
            end
            else if (running_crc != tail_word)
            begin
                r.byte_a = STATUS_CRC;
            end
            else
            begin
                r.byte_a = STATUS_OK;
            end
            r.byte_b = (events_done > 255) ? 8'd255 : events_done[7:0];
            record_queue.push_back(r);
            clear_predictor();
        end
    endtask

    // Section building. A section is assembled as bytes, then a CRC over all
    // but the last four is appended (or not, for raw noise).
    logic [7:0] sect[$];

    task automatic add_byte(input logic [7:0] b);
        sect.push_back(b);
    endtask

    task automatic rand_bytes(input int n);
        for (int i = 0; i < n; i++)
        begin
            sect.push_back(8'($urandom));
        end
    endtask

    // Header with a length field that matches the rest of the header, the body
    // and the CRC, unless len_override is not negative.
    task automatic build_section(input int n_events, input int max_desc, input int max_body,
                                 input bit good_crc, input int len_override);
        logic [7:0] body[$];
        int         nd;
        int         dl;
        int         loop_len;
        int         sl;
        logic [31:0] crc;
        body = {};
        for (int e = 0; e < n_events; e++)
        begin
            logic [7:0] descs[$];
            descs = {};
            nd = $urandom_range(0, max_desc);
            for (int d = 0; d < nd; d++)
            begin
                dl = $urandom_range(0, max_body);
                descs.push_back(8'($urandom));
                descs.push_back(8'(dl));
                for (int k = 0; k < dl; k++)
                begin
                    descs.push_back(8'($urandom));
                end
            end
            loop_len = descs.size();
            for (int k = 0; k < 10; k++)
            begin
                body.push_back(8'($urandom));
            end
            body.push_back({3'($urandom), 1'($urandom), 4'(loop_len >> 8)});
            body.push_back(8'(loop_len));
            foreach (descs[k])
            begin
                body.push_back(descs[k]);
            end
        end
        sl = (len_override >= 0) ? len_override : body.size() + 15;
        sect = {};
        add_byte(8'($urandom));
        add_byte({4'($urandom), 4'(sl >> 8)});
        add_byte(8'(sl));
        rand_bytes(11);
        foreach (body[k])
        begin
            add_byte(body[k]);
        end
        crc = 32'hFFFFFFFF;
        foreach (sect[k])
        begin
            crc = crc_update(crc, sect[k]);
        end
        if (!good_crc)
        begin
            crc ^= 32'(1) << $urandom_range(0, 31);
        end
        add_byte(crc[31:24]);
        add_byte(crc[23:16]);
        add_byte(crc[15:8]);
        add_byte(crc[7:0]);
    endtask

    task automatic queue_section();
        foreach (sect[k])
        begin
            byte_queue.push_back('{data_byte: sect[k], last_byte: (k == sect.size() - 1)});
        end
    endtask

    // Raw section of n random bytes; the last one is flagged.
    task automatic queue_noise(input int n);
        sect = {};
        rand_bytes(n);
        queue_section();
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || record_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver: presents the head of the byte queue on the falling edge, with
    // random gaps set by the current idling phase.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
        end
        else if (!(in_ch.valid && !in_accepted_q))
        begin
            // The previous transaction was taken, or nothing was on offer.
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= byte_queue[0];
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: takes bytes into the predictor and checks records.
    always @(posedge clk)
    begin
        record_t exp_rec;
        bit      busy;
        busy = 1'b0;
        in_accepted_q <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                busy = 1'b1;
                predict_byte(in_ch.payload);
                void'(byte_queue.pop_front());
            end
            if (out_ch.valid && out_ch.ready)
            begin
                busy = 1'b1;
                if (record_queue.size() == 0)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected record %p", out_ch.payload);
                    end
                end
                else
                begin
                    exp_rec = record_queue.pop_front();
                    if (out_ch.payload !== exp_rec)
                    begin
                        failed = 1'b1;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("record mismatch: expected %p", exp_rec);
                            $display("                 actual   %p", out_ch.payload);
                        end
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        failed = 1'b0;
        clear_predictor();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: a well-formed section with zero events, one with a
        // few events and descriptors, a CRC error, a short section that ends
        // before the header, a section whose length claims more than is sent
        // (truncated event), a descriptor loop overrunning the event loop,
        // and one event that may hold more than the descriptor cap.
        build_section(0, 0, 0, 1'b1, -1);
        queue_section();
        build_section(2, 3, 4, 1'b1, -1);
        queue_section();
        build_section(1, 2, 3, 1'b0, -1);
        queue_section();
        queue_noise(5);
        queue_noise(1);
        build_section(2, 2, 2, 1'b1, 4095);
        queue_section();
        build_section(1, 1, 20, 1'b1, 15 + 12);
        queue_section();
        build_section(1, 20, 0, 1'b1, -1);
        queue_section();
        // Byte values at both extremes in the header fields.
        sect = {};
        for (int k = 0; k < 20; k++)
        begin
            add_byte((k % 2) ? 8'hFF : 8'h00);
        end
        queue_section();
        wait_drained();

        // Random part in four idling phases. Mostly well-formed sections.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 46) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 46) : 0;
            for (int s = 0; s < 2; s++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_noise($urandom_range(1, 30));
                    1: build_section($urandom_range(0, 2), 3, 4, 1'b0, -1);
                    2: build_section($urandom_range(1, 2), 3, 4, 1'b1,
                                     $urandom_range(0, 4095));
                    default: build_section($urandom_range(0, 2), 3, 4, 1'b1, -1);
                endcase
                queue_section();
                // The sender pauses here until every record is in.
                wait_drained();
            end
        end

        if (!failed)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/eitp_pkg.sv
design/eitp_stream_if.sv
design/eitp_front.sv
design/eitp_queue.sv
design/eitp_back.sv
design/eit_section_parser.sv
tb/sv/eit_section_parser_test.sv
